>>> rtl/core/bsi_pkg.sv
package bsi_pkg;

   // Configuration register indexes
   localparam logic [1:0] CSR_BOX_LEFT   = 2'd0;
   localparam logic [1:0] CSR_BOX_BOTTOM = 2'd1;
   localparam logic [1:0] CSR_BOX_RIGHT  = 2'd2;
   localparam logic [1:0] CSR_BOX_TOP    = 2'd3;

   // Box corners in edge order: left-bottom, right-bottom, right-top, left-top.
   // Edge k runs from corner k to corner k+1.
   localparam int NUM_CORNERS = 4;

   // Entries in the queue between classifier and cross-product stage
   localparam int QUEUE_DEPTH = 4;

   // Classification of one request, decided without multipliers
   typedef struct packed {
      logic                   decided;      // culled or endpoint inside
      logic                   decided_hit;  // result when decided
      logic [NUM_CORNERS-1:0] edge_ok;      // edge overlap and edge straddle pass
   } flags_type;

endpackage

>>> rtl/core/box_segment_intersection_test.sv
// Channel   Handshake              Payload
// req       req_valid / req_stall  req_seg_x1, req_seg_y1, req_seg_x2, req_seg_y2
// rsp       rsp_valid / rsp_stall  rsp_hit
// csr       csr_we (no wait)       csr_index, csr_wdata
//
// One segment per clock sustained while rsp_stall is low; a taken request passes
// through the queue and the multiplier stage before the response register is loaded.
// The classifier takes a request whenever the four-entry queue has room.
// A stalled response freezes the multiplier stage; the queue absorbs requests.
// Synchronous reset clears the box registers to zero and empties the pipeline.
module box_segment_intersection_test
   import bsi_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_index,
   input  logic [COORD_BITS-1:0]        csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [COORD_BITS-1:0] req_seg_x1,
   input  logic signed [COORD_BITS-1:0] req_seg_y1,
   input  logic signed [COORD_BITS-1:0] req_seg_x2,
   input  logic signed [COORD_BITS-1:0] req_seg_y2,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_hit
);

   localparam int ITEM_BITS = 10 * (COORD_BITS + 1) + $bits(flags_type);

   logic                 push, pop, queue_full, queue_valid;
   logic [ITEM_BITS-1:0] push_data, pop_data;

   bsi_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_seg_x1 (req_seg_x1),
      .req_seg_y1 (req_seg_y1),
      .req_seg_x2 (req_seg_x2),
      .req_seg_y2 (req_seg_y2),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   bsi_queue #(.WIDTH(ITEM_BITS)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .not_empty (queue_valid),
      .pop_data  (pop_data)
   );

   bsi_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (queue_valid),
      .q_data    (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_hit   (rsp_hit)
   );

endmodule

>>> rtl/core/bsi_front.sv
module bsi_front
   import bsi_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [1:0]             csr_index,
   input  logic [COORD_BITS-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic signed [COORD_BITS-1:0] req_seg_x1,
   input  logic signed [COORD_BITS-1:0] req_seg_y1,
   input  logic signed [COORD_BITS-1:0] req_seg_x2,
   input  logic signed [COORD_BITS-1:0] req_seg_y2,
   input  logic                   queue_full,
   output logic                   push,
   output logic [10*(COORD_BITS+1)+$bits(flags_type)-1:0] push_data
);

   localparam int DW = COORD_BITS + 1;

   logic signed [COORD_BITS-1:0] left_ff, bottom_ff, right_ff, top_ff;
   logic signed [COORD_BITS-1:0] min_x, max_x, min_y, max_y;
   logic signed [COORD_BITS-1:0] lr_lo, lr_hi, bt_lo, bt_hi;
   logic signed [COORD_BITS-1:0] corner_x [NUM_CORNERS];
   logic signed [COORD_BITS-1:0] corner_y [NUM_CORNERS];
   logic signed [DW-1:0]         dd_x, dd_y;
   logic signed [DW-1:0]         off_x [NUM_CORNERS];
   logic signed [DW-1:0]         off_y [NUM_CORNERS];
   logic                         meet, in_1, in_2, x_ov, y_ov;
   logic [NUM_CORNERS-1:0]       edge_box, edge_cross;
   flags_type                    flags;

   // Hold the box registers
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= '0;
         bottom_ff <= '0;
         right_ff  <= '0;
         top_ff    <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_LEFT:   left_ff   <= csr_wdata;
            CSR_BOX_BOTTOM: bottom_ff <= csr_wdata;
            CSR_BOX_RIGHT:  right_ff  <= csr_wdata;
            CSR_BOX_TOP:    top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Take a request whenever the queue has room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // Bounds of the segment and of the box edges
   always_comb begin
      min_x = (req_seg_x1 < req_seg_x2) ? req_seg_x1 : req_seg_x2;
      max_x = (req_seg_x1 > req_seg_x2) ? req_seg_x1 : req_seg_x2;
      min_y = (req_seg_y1 < req_seg_y2) ? req_seg_y1 : req_seg_y2;
      max_y = (req_seg_y1 > req_seg_y2) ? req_seg_y1 : req_seg_y2;
      lr_lo = (left_ff < right_ff) ? left_ff : right_ff;
      lr_hi = (left_ff > right_ff) ? left_ff : right_ff;
      bt_lo = (bottom_ff < top_ff) ? bottom_ff : top_ff;
      bt_hi = (bottom_ff > top_ff) ? bottom_ff : top_ff;
   end

   // Cull against the box and check the endpoints for containment
   always_comb begin
      meet = (left_ff <= max_x) && (min_x <= right_ff) &&
             (bottom_ff <= max_y) && (min_y <= top_ff);
      in_1 = (req_seg_x1 >= left_ff) && (req_seg_x1 <= right_ff) &&
             (req_seg_y1 >= bottom_ff) && (req_seg_y1 <= top_ff);
      in_2 = (req_seg_x2 >= left_ff) && (req_seg_x2 <= right_ff) &&
             (req_seg_y2 >= bottom_ff) && (req_seg_y2 <= top_ff);
   end

   // Edge overlap and the straddle of the endpoints across each edge line
   always_comb begin
      x_ov = (min_x <= lr_hi) && (lr_lo <= max_x);
      y_ov = (min_y <= bt_hi) && (bt_lo <= max_y);
      edge_box[0] = x_ov && (min_y <= bottom_ff) && (bottom_ff <= max_y);
      edge_box[1] = y_ov && (min_x <= right_ff) && (right_ff <= max_x);
      edge_box[2] = x_ov && (min_y <= top_ff) && (top_ff <= max_y);
      edge_box[3] = y_ov && (min_x <= left_ff) && (left_ff <= max_x);
      // reject when the edge has length and both endpoints lie strictly on one side
      edge_cross[0] = (left_ff != right_ff) &&
                      (((req_seg_y1 > bottom_ff) && (req_seg_y2 > bottom_ff)) ||
                       ((req_seg_y1 < bottom_ff) && (req_seg_y2 < bottom_ff)));
      edge_cross[1] = (bottom_ff != top_ff) &&
                      (((req_seg_x1 > right_ff) && (req_seg_x2 > right_ff)) ||
                       ((req_seg_x1 < right_ff) && (req_seg_x2 < right_ff)));
      edge_cross[2] = (left_ff != right_ff) &&
                      (((req_seg_y1 > top_ff) && (req_seg_y2 > top_ff)) ||
                       ((req_seg_y1 < top_ff) && (req_seg_y2 < top_ff)));
      edge_cross[3] = (bottom_ff != top_ff) &&
                      (((req_seg_x1 > left_ff) && (req_seg_x2 > left_ff)) ||
                       ((req_seg_x1 < left_ff) && (req_seg_x2 < left_ff)));
      flags.decided     = !meet || in_1 || in_2;
      flags.decided_hit = meet && (in_1 || in_2);
      flags.edge_ok     = edge_box & ~edge_cross;
   end

   // Offsets of the segment direction and of each corner from the first endpoint
   always_comb begin
      corner_x[0] = left_ff;   corner_y[0] = bottom_ff;
      corner_x[1] = right_ff;  corner_y[1] = bottom_ff;
      corner_x[2] = right_ff;  corner_y[2] = top_ff;
      corner_x[3] = left_ff;   corner_y[3] = top_ff;
      dd_x = {req_seg_x2[COORD_BITS-1], req_seg_x2} - {req_seg_x1[COORD_BITS-1], req_seg_x1};
      dd_y = {req_seg_y2[COORD_BITS-1], req_seg_y2} - {req_seg_y1[COORD_BITS-1], req_seg_y1};
      for (int k = 0; k < NUM_CORNERS; k++) begin
         off_x[k] = {corner_x[k][COORD_BITS-1], corner_x[k]} -
                    {req_seg_x1[COORD_BITS-1], req_seg_x1};
         off_y[k] = {corner_y[k][COORD_BITS-1], corner_y[k]} -
                    {req_seg_y1[COORD_BITS-1], req_seg_y1};
      end
   end

   // Pack the queue entry
   always_comb begin
      push_data = '0;
      for (int k = 0; k < NUM_CORNERS; k++) begin
         push_data[k*DW +: DW]                 = off_y[k];
         push_data[(NUM_CORNERS+k)*DW +: DW]   = off_x[k];
      end
      push_data[2*NUM_CORNERS*DW +: DW]       = dd_y;
      push_data[(2*NUM_CORNERS+1)*DW +: DW]   = dd_x;
      push_data[10*DW +: $bits(flags_type)]   = flags;
   end

endmodule

>>> rtl/core/bsi_queue.sv
module bsi_queue
   import bsi_pkg::*;
#(
   parameter int WIDTH = 176
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[head_ff];

   // Advance pointers and count
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = (tail_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + 1'b1;
      end
      if (pop) begin
         head_in = (head_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[tail_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count beyond depth");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not step on push");

endmodule

>>> rtl/core/bsi_back.sv
module bsi_back
   import bsi_pkg::*;
#(
   parameter int COORD_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  logic [10*(COORD_BITS+1)+$bits(flags_type)-1:0] q_data,
   output logic pop,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic rsp_hit
);

   localparam int DW = COORD_BITS + 1;
   localparam int PWD = 2 * DW;

   logic signed [DW-1:0]  dd_x, dd_y;
   logic signed [DW-1:0]  off_x [NUM_CORNERS];
   logic signed [DW-1:0]  off_y [NUM_CORNERS];
   logic signed [PWD-1:0] prod_p_ff [NUM_CORNERS];
   logic signed [PWD-1:0] prod_q_ff [NUM_CORNERS];
   flags_type             q_flags, s1_flags_ff;
   logic                  s1_valid_ff, rsp_valid_ff, rsp_hit_ff, rsp_hit_in;
   logic                  advance;
   logic [NUM_CORNERS-1:0] pos, neg, edge_hit;

   // Move the whole pipeline unless the held response is stalled
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign pop       = q_valid && advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

   // Unpack the queue entry
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         off_y[k] = $signed(q_data[k*DW +: DW]);
         off_x[k] = $signed(q_data[(NUM_CORNERS+k)*DW +: DW]);
      end
      dd_y    = $signed(q_data[2*NUM_CORNERS*DW +: DW]);
      dd_x    = $signed(q_data[(2*NUM_CORNERS+1)*DW +: DW]);
      q_flags = q_data[10*DW +: $bits(flags_type)];
   end

   // Multiply the cross-product terms for every corner
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flags_ff <= q_flags;
         for (int k = 0; k < NUM_CORNERS; k++) begin
            prod_p_ff[k] <= dd_x * off_y[k];
            prod_q_ff[k] <= dd_y * off_x[k];
         end
      end
   end

   // Side of each corner, then the straddle test of each edge
   always_comb begin
      for (int k = 0; k < NUM_CORNERS; k++) begin
         pos[k] = prod_p_ff[k] > prod_q_ff[k];
         neg[k] = prod_p_ff[k] < prod_q_ff[k];
      end
      for (int k = 0; k < NUM_CORNERS; k++) begin
         edge_hit[k] = s1_flags_ff.edge_ok[k] &&
                       !((pos[k] && pos[(k+1) % NUM_CORNERS]) ||
                         (neg[k] && neg[(k+1) % NUM_CORNERS]));
      end
      rsp_hit_in = s1_flags_ff.decided ? s1_flags_ff.decided_hit : |edge_hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff  <= q_valid;
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   // Load the response register
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff <= rsp_hit_in;
      end
   end

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("product stage dropped a request while stalled");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      (!s1_valid_ff && advance) |=> !rsp_valid_ff)
      else $error("response appeared without a request in the product stage");

endmodule
